>>> design/pid_antiwindup_controller_unit_macros.svh
// assertion macros used by the checker file
`ifndef PID_ANTIWINDUP_CONTROLLER_UNIT_MACROS_SVH
`define PID_ANTIWINDUP_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PAW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid controller check failed");

// next-cycle implication, disabled while reset is low
`define PAW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid controller check failed");

// next-cycle implication that also holds across reset
`define PAW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pid controller reset check failed");

`endif

>>> design/pidaw_pkg.sv
package pidaw_pkg;

    // field and datapath widths
    localparam int unsigned GAIN_W    = 32;
    localparam int unsigned LIM_W     = 16;
    localparam int unsigned VAL_W     = 24;
    localparam int unsigned DT_W      = 16;
    localparam int unsigned INTEG_W   = 48;
    localparam int unsigned CHUNK_W   = 16;
    localparam int unsigned PROD_W    = GAIN_W + CHUNK_W;
    localparam int unsigned ACC_W     = 80;
    localparam int unsigned DIV_W     = 40;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd4;

    // configuration reset values
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 32'sh0001_0000;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST    = 32'sh0000_0000;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = 32'sh0000_0000;
    localparam logic signed [LIM_W-1:0]  DRIVE_MIN_RST = 16'shC000;
    localparam logic signed [LIM_W-1:0]  DRIVE_MAX_RST = 16'sh4000;

    // opcodes and status codes
    localparam logic OP_COMPUTE   = 1'b0;
    localparam logic OP_CLEAR     = 1'b1;
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_ZERO_DT = 1'b1;

    // saturation bound of one gain product, Q.32
    localparam logic [ACC_W-1:0] TERM_LIM = 80'h1 << 60;

    typedef struct packed {
        logic                    opcode;
        logic signed [VAL_W-1:0] setpoint;
        logic signed [VAL_W-1:0] measured;
        logic [DT_W-1:0]         step_time;
    } t_in_beat;

    typedef struct packed {
        logic signed [LIM_W-1:0] drive;
        logic                    status;
    } t_out_beat;

endpackage

>>> design/pidaw_mac.sv
module pidaw_mac
    import pidaw_pkg::*;
(
    input  logic [ACC_W-1:0]   i_acc,
    input  logic [GAIN_W-1:0]  i_mul_a,
    input  logic [CHUNK_W-1:0] i_mul_b,
    output logic [ACC_W-1:0]   o_acc
);

    logic [PROD_W-1:0] w_prod;

    // one 32x16 partial product, folded into the shifted accumulator
    assign w_prod = {{CHUNK_W{1'b0}}, i_mul_a} * {{GAIN_W{1'b0}}, i_mul_b};
    assign o_acc  = {i_acc[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                  + {{(ACC_W-PROD_W){1'b0}}, w_prod};

endmodule

>>> design/pid_antiwindup_controller_unit.sv
// channel   direction  signals                          payload
// input     in         i_in_valid / o_in_ready          i_in  (t_in_beat)
// result    out        o_out_valid / i_out_ready        o_out (t_out_beat)
// config    in         i_cfg_we, i_cfg_idx              i_cfg_data, no wait
//
// a compute beat goes from acceptance to the result register through the
// 40-step restoring divider, skipped on the first step after a clear or
// reset when there is no derivative history, and through four gain
// products, each three 32x16 passes through the one shared multiplier
// a zero time step beat goes straight to the result stage; a clear beat
// is absorbed at acceptance and the input is ready again the next cycle
// reset is synchronous and active low; a waiting result holds the next beat
// at its final step until the result register frees up
module pid_antiwindup_controller_unit
    import pidaw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDT,
        S_CAND,
        S_DIV,
        S_DSGN,
        S_MLD,
        S_MUL,
        S_MSAT,
        S_FIN,
        S_OUT
    } t_state;

    // gain product order
    localparam logic [1:0] TERM_P  = 2'd0;
    localparam logic [1:0] TERM_D  = 2'd1;
    localparam logic [1:0] TERM_IC = 2'd2;
    localparam logic [1:0] TERM_IO = 2'd3;

    t_state r_state, n_state;

    logic signed [GAIN_W-1:0]  r_gain_p, n_gain_p;
    logic signed [GAIN_W-1:0]  r_gain_i, n_gain_i;
    logic signed [GAIN_W-1:0]  r_gain_d, n_gain_d;
    logic signed [LIM_W-1:0]   r_drive_min, n_drive_min;
    logic signed [LIM_W-1:0]   r_drive_max, n_drive_max;

    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [VAL_W-1:0]   r_last, n_last;
    logic                      r_hist, n_hist;

    logic signed [VAL_W:0]     r_err, n_err;
    logic signed [VAL_W:0]     r_dif, n_dif;
    logic signed [VAL_W-1:0]   r_ms, n_ms;
    logic [DT_W-1:0]           r_dt, n_dt;
    logic signed [INTEG_W-1:0] r_cand, n_cand;
    logic [DIV_W-1:0]          r_num, n_num;
    logic [DT_W-1:0]           r_rem, n_rem;
    logic [5:0]                r_cnt, n_cnt;
    logic signed [DIV_W:0]     r_deriv, n_deriv;
    logic [1:0]                r_term, n_term;
    logic [GAIN_W-1:0]         r_ka, n_ka;
    logic [INTEG_W-1:0]        r_xm, n_xm;
    logic                      r_neg, n_neg;
    logic [1:0]                r_chunk, n_chunk;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic signed [63:0]        r_pd, n_pd;
    logic signed [63:0]        r_tc, n_tc;
    logic signed [63:0]        r_to, n_to;
    t_out_beat                 r_pend, n_pend;
    t_out_beat                 r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic [ACC_W-1:0]          w_mac_acc;
    logic [GAIN_W-1:0]         w_mac_a;
    logic [CHUNK_W-1:0]        w_mac_b;
    logic [ACC_W-1:0]          w_mac_out;

    logic [VAL_W:0]            w_err_mag;
    logic [VAL_W:0]            w_dif_mag;
    logic signed [DIV_W:0]     w_eprod;
    logic signed [VAL_W:0]     w_inc;
    logic signed [INTEG_W:0]   w_cand_wide;
    logic [DT_W:0]             w_rem_sh;
    logic                      w_ge;
    logic [DT_W:0]             w_rem_nx;
    logic signed [GAIN_W-1:0]  w_ksel;
    logic signed [INTEG_W-1:0] w_xsel;
    logic [60:0]               w_psat;
    logic signed [63:0]        w_term;
    logic signed [63:0]        w_hi;
    logic signed [63:0]        w_lo;
    logic                      w_hold;
    logic signed [63:0]        w_total;
    logic signed [LIM_W-1:0]   w_drive;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared multiplier: error times step, or one chunk of a gain product
    assign w_mac_acc = (r_state == S_MUL) ? r_acc : '0;
    assign w_mac_a   = (r_state == S_MUL) ? r_ka : {{(GAIN_W-VAL_W-1){1'b0}}, w_err_mag};
    assign w_mac_b   = (r_state == S_MUL) ? r_xm[INTEG_W-1 -: CHUNK_W] : r_dt;

    pidaw_mac u_mac (
        .i_acc   (w_mac_acc),
        .i_mul_a (w_mac_a),
        .i_mul_b (w_mac_b),
        .o_acc   (w_mac_out)
    );

    // magnitudes of error and measurement difference
    assign w_err_mag = r_err[VAL_W] ? (VAL_W+1)'(-r_err) : (VAL_W+1)'(r_err);
    assign w_dif_mag = r_dif[VAL_W] ? (VAL_W+1)'(-r_dif) : (VAL_W+1)'(r_dif);

    // candidate integral: floor of error*dt/2^16 added with saturation
    assign w_eprod = r_err[VAL_W] ? -$signed({1'b0, r_acc[DIV_W-1:0]})
                                  :  $signed({1'b0, r_acc[DIV_W-1:0]});
    assign w_inc   = w_eprod[DIV_W:16];
    assign w_cand_wide = $signed({r_integ[INTEG_W-1], r_integ})
                       + $signed({{(INTEG_W-VAL_W){w_inc[VAL_W]}}, w_inc});

    // restoring divider step
    assign w_rem_sh = {r_rem, r_num[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dt});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_dt}) : w_rem_sh;

    // operand select for the current gain product
    always_comb begin
        case (r_term)
            TERM_P: begin
                w_ksel = r_gain_p;
                w_xsel = {{(INTEG_W-VAL_W-1){r_err[VAL_W]}}, r_err};
            end
            TERM_D: begin
                w_ksel = r_gain_d;
                w_xsel = {{(INTEG_W-DIV_W-1){r_deriv[DIV_W]}}, r_deriv};
            end
            TERM_IC: begin
                w_ksel = r_gain_i;
                w_xsel = r_cand;
            end
            default: begin
                w_ksel = r_gain_i;
                w_xsel = r_integ;
            end
        endcase
    end

    // saturated, signed gain product
    assign w_psat = (r_acc > TERM_LIM) ? TERM_LIM[60:0] : r_acc[60:0];
    assign w_term = r_neg ? -$signed({3'b000, w_psat}) : $signed({3'b000, w_psat});

    // limits in Q.32 and the anti-windup decision
    assign w_hi    = {{30{r_drive_max[LIM_W-1]}}, r_drive_max, 18'b0};
    assign w_lo    = {{30{r_drive_min[LIM_W-1]}}, r_drive_min, 18'b0};
    assign w_hold  = ((r_tc > w_hi) && !r_err[VAL_W] && (r_err != '0))
                  || ((r_tc < w_lo) && r_err[VAL_W]);
    assign w_total = w_hold ? r_to : r_tc;

    // clamp, upper limit first
    always_comb begin
        if (w_total > w_hi) begin
            w_drive = r_drive_max;
        end else if (w_total < w_lo) begin
            w_drive = r_drive_min;
        end else begin
            w_drive = w_total[33:18];
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_gain_p    = r_gain_p;
        n_gain_i    = r_gain_i;
        n_gain_d    = r_gain_d;
        n_drive_min = r_drive_min;
        n_drive_max = r_drive_max;
        n_integ     = r_integ;
        n_last      = r_last;
        n_hist      = r_hist;
        n_err       = r_err;
        n_dif       = r_dif;
        n_ms        = r_ms;
        n_dt        = r_dt;
        n_cand      = r_cand;
        n_num       = r_num;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_deriv     = r_deriv;
        n_term      = r_term;
        n_ka        = r_ka;
        n_xm        = r_xm;
        n_neg       = r_neg;
        n_chunk     = r_chunk;
        n_acc       = r_acc;
        n_pd        = r_pd;
        n_tc        = r_tc;
        n_to        = r_to;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_P:    n_gain_p    = i_cfg_data;
                CFG_GAIN_I:    n_gain_i    = i_cfg_data;
                CFG_GAIN_D:    n_gain_d    = i_cfg_data;
                CFG_DRIVE_MIN: n_drive_min = i_cfg_data[LIM_W-1:0];
                CFG_DRIVE_MAX: n_drive_max = i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end

        // result beat taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.opcode == OP_CLEAR) begin
                        n_integ = '0;
                        n_last  = '0;
                        n_hist  = 1'b0;
                    end else if (i_in.step_time == '0) begin
                        n_pend.drive  = '0;
                        n_pend.status = STAT_ZERO_DT;
                        n_state       = S_OUT;
                    end else begin
                        n_err   = {i_in.setpoint[VAL_W-1], i_in.setpoint}
                                - {i_in.measured[VAL_W-1], i_in.measured};
                        n_dif   = {r_last[VAL_W-1], r_last}
                                - {i_in.measured[VAL_W-1], i_in.measured};
                        n_ms    = i_in.measured;
                        n_dt    = i_in.step_time;
                        n_state = S_EDT;
                    end
                end
            end
            S_EDT: begin
                n_acc   = w_mac_out;
                n_state = S_CAND;
            end
            S_CAND: begin
                if (w_cand_wide[INTEG_W] != w_cand_wide[INTEG_W-1]) begin
                    n_cand = w_cand_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                                  : {1'b0, {(INTEG_W-1){1'b1}}};
                end else begin
                    n_cand = w_cand_wide[INTEG_W-1:0];
                end
                n_num = {w_dif_mag[VAL_W-1:0], {(DIV_W-VAL_W){1'b0}}};
                n_rem = '0;
                n_cnt = 6'(DIV_W - 1);
                if (r_hist) begin
                    n_state = S_DIV;
                end else begin
                    n_deriv = '0;
                    n_term  = TERM_P;
                    n_state = S_MLD;
                end
            end
            S_DIV: begin
                n_rem = w_rem_nx[DT_W-1:0];
                n_num = {r_num[DIV_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = S_DSGN;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_DSGN: begin
                n_deriv = r_dif[VAL_W] ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
                n_term  = TERM_P;
                n_state = S_MLD;
            end
            S_MLD: begin
                n_ka    = w_ksel[GAIN_W-1] ? GAIN_W'(-w_ksel) : GAIN_W'(w_ksel);
                n_xm    = w_xsel[INTEG_W-1] ? INTEG_W'(-w_xsel) : INTEG_W'(w_xsel);
                n_neg   = w_ksel[GAIN_W-1] ^ w_xsel[INTEG_W-1];
                n_acc   = '0;
                n_chunk = 2'd2;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_acc = w_mac_out;
                n_xm  = {r_xm[INTEG_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                if (r_chunk == '0) begin
                    n_state = S_MSAT;
                end else begin
                    n_chunk = r_chunk - 2'd1;
                end
            end
            S_MSAT: begin
                case (r_term)
                    TERM_P:  n_pd = w_term;
                    TERM_D:  n_pd = r_pd + w_term;
                    TERM_IC: n_tc = r_pd + w_term;
                    default: n_to = r_pd + w_term;
                endcase
                if (r_term == TERM_IO) begin
                    n_state = S_FIN;
                end else begin
                    n_term  = r_term + 2'd1;
                    n_state = S_MLD;
                end
            end
            S_FIN: begin
                if (!w_hold) begin
                    n_integ = r_cand;
                end
                n_pend.drive  = w_drive;
                n_pend.status = STAT_OK;
                n_last        = r_ms;
                n_hist        = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, configuration and result registers
    always_ff @(posedge i_clk) begin
        r_err   <= n_err;
        r_dif   <= n_dif;
        r_ms    <= n_ms;
        r_dt    <= n_dt;
        r_cand  <= n_cand;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_deriv <= n_deriv;
        r_term  <= n_term;
        r_ka    <= n_ka;
        r_xm    <= n_xm;
        r_neg   <= n_neg;
        r_chunk <= n_chunk;
        r_acc   <= n_acc;
        r_pd    <= n_pd;
        r_tc    <= n_tc;
        r_to    <= n_to;
        r_pend  <= n_pend;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_drive_min <= DRIVE_MIN_RST;
            r_drive_max <= DRIVE_MAX_RST;
            r_integ     <= '0;
            r_last      <= '0;
            r_hist      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gain_p    <= n_gain_p;
            r_gain_i    <= n_gain_i;
            r_gain_d    <= n_gain_d;
            r_drive_min <= n_drive_min;
            r_drive_max <= n_drive_max;
            r_integ     <= n_integ;
            r_last      <= n_last;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/pidaw_checker.sv
`include "pid_antiwindup_controller_unit_macros.svh"

module pidaw_checker
    import pidaw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out
);

    // a stalled result beat stays offered
    `PAW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled result beat keeps its payload
    `PAW_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out))

    // a compute beat occupies the sequencer for at least the next cycle
    `PAW_ASSERT_NEXT(a_busy_after_compute, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in.opcode == OP_COMPUTE), !i_in_ready)

    // a rejected time step always reports a zero drive
    `PAW_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, i_out_valid && (i_out.status == STAT_ZERO_DT), i_out.drive == '0)

    // reset empties the result register
    `PAW_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind pid_antiwindup_controller_unit pidaw_checker u_pidaw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

>>> tb/tb_pid_antiwindup_controller_unit.sv
`timescale 1ns / 1ps

module tb_pid_antiwindup_controller_unit;
    import pidaw_pkg::*;

    localparam int     SETTLE_CYCLES = 80;
    localparam int     DRAIN_LIMIT   = 2000;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     RAND_PHASES   = 10;
    localparam int     RAND_PER_PH   = 188;
    localparam longint LIM_SCALE     = 262144;
    localparam longint INTEG_HI      = (longint'(1) <<< 47) - 1;
    localparam longint INTEG_LO      = -INTEG_HI - 1;
    localparam longint TERM_CAP      = longint'(1) <<< 60;
    localparam logic signed [127:0] PROD_CAP = 128'sd1 <<< 60;

    // dut ports
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 o_in_ready;
    t_in_beat             in_beat    = '0;
    logic                 o_out_valid;
    logic                 out_ready  = 1'b0;
    t_out_beat            o_out;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [CFG_DAT_W-1:0] cfg_data   = '0;

    // command beats waiting to be sent, front one is on the bus while offered
    t_in_beat  cmd_q[$];
    // drive results owed by the controller, oldest first
    t_out_beat drive_due_q[$];
    t_out_beat due_beat;

    // shadow of the controller registers and loop state
    logic [GAIN_W-1:0] cfg_kp   = GAIN_P_RST;
    logic [GAIN_W-1:0] cfg_ki   = GAIN_I_RST;
    logic [GAIN_W-1:0] cfg_kd   = GAIN_D_RST;
    logic [LIM_W-1:0]  cfg_dmin = DRIVE_MIN_RST;
    logic [LIM_W-1:0]  cfg_dmax = DRIVE_MAX_RST;
    longint            integ_acc = 0;
    longint            last_meas = 0;
    logic              have_hist = 1'b0;

    // random trajectory of setpoint and plant position
    logic [VAL_W-1:0] traj_sp = '0;
    logic [VAL_W-1:0] traj_ms = '0;

    int          mismatch_cnt = 0;
    int          results_seen = 0;
    int          gap_left     = 0;
    int          hold_left    = 0;
    int          quiet_cnt    = 0;
    int          drain_wait;
    logic [31:0] cyc_cnt      = '0;
    logic        calm;

    pid_antiwindup_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stretches with no idling on either side
    assign calm = (cyc_cnt[9:8] == 2'b11);

    // gain product clamped to +-2^60
    function automatic longint clamp_term(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa = a;
        wb = b;
        prod = wa * wb;
        if (prod > PROD_CAP) return TERM_CAP;
        if (prod < -PROD_CAP) return -TERM_CAP;
        return prod[63:0];
    endfunction

    // advance the loop state by one accepted beat, queue the drive it owes
    task automatic predict_drive(input t_in_beat b);
        longint    ms;
        longint    err;
        longint    dt;
        longint    rate;
        longint    cand;
        longint    pd;
        longint    total;
        longint    lo;
        longint    hi;
        longint    kp;
        longint    ki;
        longint    kd;
        longint    shifted;
        t_out_beat res;
        res = '0;
        if (b.opcode == OP_CLEAR) begin
            integ_acc = 0;
            last_meas = 0;
            have_hist = 1'b0;
        end else if (b.step_time == '0) begin
            res.drive  = '0;
            res.status = STAT_ZERO_DT;
            drive_due_q.push_back(res);
        end else begin
            ms  = $signed(b.measured);
            err = $signed(b.setpoint);
            err = err - ms;
            dt  = b.step_time;
            kp  = $signed(cfg_kp);
            ki  = $signed(cfg_ki);
            kd  = $signed(cfg_kd);
            lo  = $signed(cfg_dmin);
            hi  = $signed(cfg_dmax);
            lo  = lo * LIM_SCALE;
            hi  = hi * LIM_SCALE;

            // derivative on measurement, none on the first step
            rate = 0;
            if (have_hist) rate = ((last_meas - ms) * 65536) / dt;
            have_hist = 1'b1;

            cand = integ_acc + ((err * dt) >>> 16);
            if (cand > INTEG_HI) cand = INTEG_HI;
            else if (cand < INTEG_LO) cand = INTEG_LO;

            // integrate only when it does not push deeper into a limit
            pd    = clamp_term(kp, err) + clamp_term(kd, rate);
            total = pd + clamp_term(ki, cand);
            if (!((total > hi && err > 0) || (total < lo && err < 0))) integ_acc = cand;
            total = pd + clamp_term(ki, integ_acc);

            // upper limit tested first
            if (total > hi) begin
                res.drive = cfg_dmax;
            end else if (total < lo) begin
                res.drive = cfg_dmin;
            end else begin
                shifted   = total >>> 18;
                res.drive = shifted[15:0];
            end
            res.status = STAT_OK;
            last_meas  = ms;
            drive_due_q.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 40) $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // position: mostly near zero, some anywhere, a few at the ends
    function automatic int pick_position();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return int'($urandom_range(0, 262144)) - 131072;
        if (k < 90) return int'($urandom());
        case ($urandom_range(0, 3))
            0:       return 32'h007F_FFFF;
            1:       return -8388608;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int pick_step();
        int          k;
        logic [31:0] r;
        k = $urandom_range(0, 99);
        r = $urandom();
        if (k < 5) return 0;
        if (k < 10) return 1;
        if (k < 15) return 65535;
        if (k < 30) return int'(r[15:0]);
        return int'(r[11:0]) + 1;
    endfunction

    function automatic logic [31:0] pick_gain();
        int          k;
        logic [31:0] r;
        k = $urandom_range(0, 9);
        r = $urandom();
        case (k)
            0:       return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return '0;
            2, 3:    return 32'($signed(r[17:0]));
            4, 5:    return 32'($signed(r[20:0]));
            6:       return 32'($signed(r[24:0]));
            7:       return r;
            default: return 32'($signed(r[15:0]));
        endcase
    endfunction

    task automatic pick_limits(output int lo, output int hi);
        int          k;
        logic [31:0] r;
        k = $urandom_range(0, 9);
        r = $urandom();
        case (k)
            0: begin
                lo = -16384;
                hi = 16384;
            end
            1: begin
                lo = -int'($urandom_range(0, 16384));
                hi = $urandom_range(0, 16384);
            end
            2: begin
                // either order, swapped limits included
                lo = int'($urandom_range(0, 32768)) - 16384;
                hi = int'($urandom_range(0, 32768)) - 16384;
            end
            3: begin
                lo = int'($urandom_range(0, 32768)) - 16384;
                hi = lo;
            end
            4: begin
                // anywhere in the register, beyond +-1.0 too
                lo = $signed(r[15:0]);
                hi = $signed(r[31:16]);
            end
            default: begin
                lo = -int'($urandom_range(0, 4096));
                hi = $urandom_range(0, 4096);
            end
        endcase
    endtask

    task automatic push_item(input logic op, input int sp, input int ms, input int dt);
        t_in_beat b;
        b.opcode    = op;
        b.setpoint  = sp[VAL_W-1:0];
        b.measured  = ms[VAL_W-1:0];
        b.step_time = dt[DT_W-1:0];
        cmd_q.push_back(b);
    endtask

    // mostly a plant tracking its setpoint, some jumps, a few clears
    task automatic push_random(input int n);
        int v;
        int nxt;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 4) begin
                push_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
            end else begin
                if ($urandom_range(0, 11) == 0) begin
                    v = pick_position();
                    traj_sp = v[VAL_W-1:0];
                end
                if ($urandom_range(0, 9) == 0) begin
                    v = pick_position();
                    traj_ms = v[VAL_W-1:0];
                end else begin
                    nxt = int'($signed(traj_ms))
                        + (int'($signed(traj_sp)) - int'($signed(traj_ms))) / 8
                        + int'($urandom_range(0, 2048)) - 1024;
                    traj_ms = nxt[VAL_W-1:0];
                end
                push_item(OP_COMPUTE, int'($signed(traj_sp)), int'($signed(traj_ms)),
                          pick_step());
            end
        end
    endtask

    // registers change only with the controller idle and the loop drained
    task automatic wait_drained();
        while (cmd_q.size() != 0 || drive_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_GAIN_P:    cfg_kp   = data;
            CFG_GAIN_I:    cfg_ki   = data;
            CFG_GAIN_D:    cfg_kd   = data;
            CFG_DRIVE_MIN: cfg_dmin = data[LIM_W-1:0];
            CFG_DRIVE_MAX: cfg_dmax = data[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input int lo, input int hi);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_DRIVE_MIN, lo);
        write_reg(CFG_DRIVE_MAX, hi);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // command driver: holds a beat until taken, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (in_valid && !o_in_ready) begin
            // beat still offered, hold it
        end else begin
            if (in_valid && o_in_ready) begin
                predict_drive(in_beat);
                cmd_q.delete(0);
                gap_left = calm ? 0 : pick_gap();
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                in_valid <= 1'b1;
                in_beat  <= cmd_q[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure and a few long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (drive_due_q.size() == 0) begin
                    report_mismatch($sformatf("result with none owed: drive %0d status %0d",
                                              $signed(o_out.drive), o_out.status));
                end else begin
                    due_beat = drive_due_q.pop_front();
                    if (o_out.drive !== due_beat.drive)
                        report_mismatch($sformatf("drive got %0d, owed %0d",
                                                  $signed(o_out.drive),
                                                  $signed(due_beat.drive)));
                    if (o_out.status !== due_beat.status)
                        report_mismatch($sformatf("status got %0d, owed %0d",
                                                  o_out.status, due_beat.status));
                end
                results_seen++;
                // long hold so the controller backs up into its input
                if (results_seen % 700 == 50) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (calm || $urandom_range(0, 99) < 70) begin
                out_ready <= 1'b1;
            end else begin
                hold_left = pick_gap();
                out_ready <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (!i_rst_n || cfg_we || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // stimulus sequence
    initial begin
        int lo;
        int hi;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains: first step, extremes, zero step, clear
        push_item(OP_COMPUTE, 0, 0, 1000);
        push_item(OP_COMPUTE, 32'h007F_FFFF, -8388608, 65535);
        push_item(OP_COMPUTE, -8388608, 32'h007F_FFFF, 1);
        push_item(OP_COMPUTE, 12345, -3, 0);
        push_item(OP_CLEAR, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF);
        push_item(OP_COMPUTE, 32'h4000, 0, 655);
        wait_drained();

        // windup against the limit, unwind, derivative kick, clear
        apply_config(32'h0001_0000, 32'h0010_0000, 32'h0000_8000, -16384, 16384);
        repeat (4) push_item(OP_COMPUTE, 32'h8000, 0, 65535);
        push_item(OP_COMPUTE, -32'sh8000, 0, 65535);
        push_item(OP_COMPUTE, 0, 32'h1000, 100);
        push_item(OP_COMPUTE, 0, 32'h3000, 100);
        push_item(OP_CLEAR, 0, 0, 0);
        push_item(OP_COMPUTE, 32'h100, 32'h2000, 50);
        push_item(OP_COMPUTE, 32'h100, 32'h2100, 50);
        wait_drained();

        // extreme gains
        apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -16384, 16384);
        push_item(OP_COMPUTE, 1, 0, 1);
        push_item(OP_COMPUTE, 0, 1, 1);
        push_item(OP_COMPUTE, 0, 0, 65535);
        wait_drained();

        // opposite extremes with swapped limits
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16384, -16384);
        push_item(OP_COMPUTE, 32'h10, 0, 300);
        push_item(OP_COMPUTE, -16, 0, 300);
        push_item(OP_COMPUTE, 0, 0, 300);
        wait_drained();

        // limits beyond +-1.0
        apply_config(32'h0000_8000, 32'h0, 32'h0, -32768, 32767);
        push_item(OP_COMPUTE, 32'h007F_FFFF, 0, 1000);
        push_item(OP_COMPUTE, -8388608, 0, 1000);
        push_item(OP_COMPUTE, 32'h1000, 0, 1000);

        // random settings, each phase starts from a drained loop
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            pick_limits(lo, hi);
            apply_config(pick_gain(), pick_gain(), pick_gain(), lo, hi);
            push_random(RAND_PER_PH);
        end

        while (cmd_q.size() != 0) @(posedge i_clk);
        for (drain_wait = 0; drain_wait < DRAIN_LIMIT && drive_due_q.size() != 0;
             drain_wait++)
            @(posedge i_clk);
        if (drive_due_q.size() != 0)
            report_mismatch($sformatf("%0d drive results never arrived", drive_due_q.size()));
        repeat (100) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
